// ===== hw/rtl/sbpe_pkg.sv =====
// Shared types, protocol codes and the microcode ROM for the servo bus packet engine.
// No dependencies; used by servo_bus_packet_engine_unit.
package sbpe_pkg;

  localparam int MAX_PACKET_BYTES = 11;

  // divide by 100: floor(x * RECIP_100 >> RECIP_SHIFT), exact for x < 91180
  localparam int RECIP_SHIFT = 23;
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam logic [8:0]  ANGLE_SCALE = 9'd341;
  localparam logic [11:0] POS_CENTER = 12'd665;
  localparam logic [9:0]  POS_MAX = 10'd1023;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] ID_BROADCAST  = 8'hFE;
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_REG_WRITE = 8'h04;
  localparam logic [7:0] INS_ACTION    = 8'h05;
  localparam logic [7:0] ADDR_GOAL     = 8'h1E;
  localparam logic [7:0] ADDR_SPEED    = 8'h20;
  localparam logic [7:0] ADDR_POS      = 8'h24;
  localparam logic [7:0] ADDR_MOVING   = 8'h2E;
  localparam logic [7:0] ADDR_CW_LIMIT = 8'h06;
  localparam logic [7:0] WHEEL_FWD     = 8'h04;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [2:0] {
    OP_GOAL, OP_WHEEL, OP_READ_POS, OP_READ_MOV,
    OP_WHEEL_MODE, OP_JOINT_MODE, OP_ACTION, OP_RX
  } op_t;

  typedef enum logic [1:0] {
    RK_ACK, RK_POS, RK_MOV
  } reply_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_RX
  } state_t;

  typedef enum logic [1:0] {
    ACT_EMIT, ACT_MUL1, ACT_MUL2, ACT_JMP
  } act_t;

  typedef enum logic [3:0] {
    SRC_HDR, SRC_ID, SRC_IMM, SRC_INS, SRC_POSL, SRC_POSH,
    SRC_SPDL, SRC_SPDH, SRC_VELL, SRC_VELH, SRC_SUM
  } src_t;

  typedef enum logic {
    CND_ALWAYS, CND_JOINT
  } cnd_t;

  typedef logic [5:0] upc_t;

  typedef struct packed {
    act_t       act;
    src_t       src;
    logic [7:0] imm;
    cnd_t       cnd;
    upc_t       target;
    logic       done;
  } ucw_t;

  localparam upc_t PC_GOAL      = 6'd0;
  localparam upc_t PC_WHEEL     = 6'd13;
  localparam upc_t PC_READ_POS  = 6'd22;
  localparam upc_t PC_READ_MOV  = 6'd30;
  localparam upc_t PC_MODE      = 6'd38;
  localparam upc_t PC_MODE_SUM  = 6'd49;
  localparam upc_t PC_JOINT     = 6'd50;
  localparam upc_t PC_ACTION    = 6'd53;

  function automatic ucw_t u_base();
    ucw_t w;
    w.act    = ACT_EMIT;
    w.src    = SRC_IMM;
    w.imm    = 8'h00;
    w.cnd    = CND_ALWAYS;
    w.target = '0;
    w.done   = 1'b0;
    return w;
  endfunction

  function automatic ucw_t u_src(src_t s);
    ucw_t w;
    w = u_base();
    w.src = s;
    return w;
  endfunction

  function automatic ucw_t u_imm(logic [7:0] v);
    ucw_t w;
    w = u_base();
    w.imm = v;
    return w;
  endfunction

  function automatic ucw_t u_sum();
    ucw_t w;
    w = u_base();
    w.src  = SRC_SUM;
    w.done = 1'b1;
    return w;
  endfunction

  function automatic ucw_t u_act(act_t a);
    ucw_t w;
    w = u_base();
    w.act = a;
    return w;
  endfunction

  function automatic ucw_t u_jmp(cnd_t c, upc_t t);
    ucw_t w;
    w = u_base();
    w.act    = ACT_JMP;
    w.cnd    = c;
    w.target = t;
    return w;
  endfunction

  function automatic ucw_t ucode(upc_t pc);
    ucw_t w;
    case (pc)
      // goal position
      6'd0:  w = u_act(ACT_MUL1);
      6'd1:  w = u_act(ACT_MUL2);
      6'd2:  w = u_src(SRC_HDR);
      6'd3:  w = u_src(SRC_HDR);
      6'd4:  w = u_src(SRC_ID);
      6'd5:  w = u_imm(8'd7);
      6'd6:  w = u_src(SRC_INS);
      6'd7:  w = u_imm(ADDR_GOAL);
      6'd8:  w = u_src(SRC_POSL);
      6'd9:  w = u_src(SRC_POSH);
      6'd10: w = u_src(SRC_SPDL);
      6'd11: w = u_src(SRC_SPDH);
      6'd12: w = u_sum();
      // wheel speed
      6'd13: w = u_src(SRC_HDR);
      6'd14: w = u_src(SRC_HDR);
      6'd15: w = u_src(SRC_ID);
      6'd16: w = u_imm(8'd5);
      6'd17: w = u_src(SRC_INS);
      6'd18: w = u_imm(ADDR_SPEED);
      6'd19: w = u_src(SRC_VELL);
      6'd20: w = u_src(SRC_VELH);
      6'd21: w = u_sum();
      // read position
      6'd22: w = u_src(SRC_HDR);
      6'd23: w = u_src(SRC_HDR);
      6'd24: w = u_src(SRC_ID);
      6'd25: w = u_imm(8'd4);
      6'd26: w = u_imm(INS_READ);
      6'd27: w = u_imm(ADDR_POS);
      6'd28: w = u_imm(8'd2);
      6'd29: w = u_sum();
      // read moving flag
      6'd30: w = u_src(SRC_HDR);
      6'd31: w = u_src(SRC_HDR);
      6'd32: w = u_src(SRC_ID);
      6'd33: w = u_imm(8'd4);
      6'd34: w = u_imm(INS_READ);
      6'd35: w = u_imm(ADDR_MOVING);
      6'd36: w = u_imm(8'd1);
      6'd37: w = u_sum();
      // wheel / joint mode: angle limits
      6'd38: w = u_src(SRC_HDR);
      6'd39: w = u_src(SRC_HDR);
      6'd40: w = u_src(SRC_ID);
      6'd41: w = u_imm(8'd7);
      6'd42: w = u_imm(INS_WRITE);
      6'd43: w = u_imm(ADDR_CW_LIMIT);
      6'd44: w = u_imm(8'h00);
      6'd45: w = u_imm(8'h00);
      6'd46: w = u_jmp(CND_JOINT, PC_JOINT);
      6'd47: w = u_imm(8'h00);
      6'd48: w = u_imm(8'h00);
      6'd49: w = u_sum();
      6'd50: w = u_imm(8'hFF);
      6'd51: w = u_imm(8'h03);
      6'd52: w = u_jmp(CND_ALWAYS, PC_MODE_SUM);
      // broadcast action
      6'd53: w = u_src(SRC_HDR);
      6'd54: w = u_src(SRC_HDR);
      6'd55: w = u_imm(ID_BROADCAST);
      6'd56: w = u_imm(8'd2);
      6'd57: w = u_imm(INS_ACTION);
      default: w = u_sum();
    endcase
    return w;
  endfunction

  function automatic upc_t entry_pc(op_t op);
    case (op)
      OP_GOAL:       return PC_GOAL;
      OP_WHEEL:      return PC_WHEEL;
      OP_READ_POS:   return PC_READ_POS;
      OP_READ_MOV:   return PC_READ_MOV;
      OP_WHEEL_MODE: return PC_MODE;
      OP_JOINT_MODE: return PC_MODE;
      default:       return PC_ACTION;
    endcase
  endfunction

  // full packet length including header and checksum
  function automatic logic [4:0] pkt_len(op_t op);
    case (op)
      OP_GOAL, OP_WHEEL_MODE, OP_JOINT_MODE: return 5'd11;
      OP_WHEEL:                              return 5'd9;
      OP_READ_POS, OP_READ_MOV:              return 5'd8;
      default:                               return 5'd6;
    endcase
  endfunction

  function automatic logic [3:0] reply_len(op_t op);
    case (op)
      OP_READ_POS: return 4'd8;
      OP_READ_MOV: return 4'd7;
      OP_ACTION:   return 4'd0;
      default:     return 4'd6;
    endcase
  endfunction

  function automatic reply_t reply_of(op_t op);
    case (op)
      OP_READ_POS: return RK_POS;
      OP_READ_MOV: return RK_MOV;
      default:     return RK_ACK;
    endcase
  endfunction

endpackage

// ===== hw/rtl/servo_bus_packet_engine_unit.sv =====
// Servo bus packet engine top level: input latch, microcode sequencer, datapath, output register.
// Depends on sbpe_pkg (codes, control word type, microcode ROM).
//
// Usage:
//   Input stream s_*: one beat is a command or a received status byte. s_tuser holds op;
//   ops 0..6 build one instruction packet, op 7 feeds one byte of the servo's reply.
//   Output stream m_*: m_tuser = 0 beats are packet bytes in order, m_tlast on the
//   checksum byte; m_tuser = 1 is a status report (status_ok, value) issued when the
//   awaited reply length has been counted.
//   Timing: a command beat runs a microprogram of one step per cycle; each packet byte
//   step waits for the output register to be free. Goal position has two extra steps
//   for the multiply and the divide by 100; joint/wheel mode adds one jump step, joint
//   mode two. s_tready is high only while the sequencer is idle, so at most one beat
//   is in work; the last result may still sit in the output register while the next
//   beat is taken.
//   Stall: a full output register with low m_tready holds a byte or report step.
//   Reset clears the sequencer, the output valid flag and the reply tracking; no reply
//   is awaited after reset.
module servo_bus_packet_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // servo_id, goal_angle, speed, deferred, rx_byte, pad
  input  logic [2:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // tx_byte, status_ok, value, pad
  output logic        m_tlast,
  output logic        m_tuser    // kind
);

  sbpe_pkg::state_t state, state_next;
  sbpe_pkg::upc_t   pc;
  sbpe_pkg::op_t    op_q;
  sbpe_pkg::ucw_t   uw;

  logic [7:0]        id_q;
  logic signed [8:0] ang_q;
  logic signed [10:0] spd_q;
  logic              dfr_q;
  logic [7:0]        rxb_q;
  logic [16:0]       prod1;
  logic [9:0]        quo;
  logic [7:0]        tx_sum;

  logic [3:0]        rx_expected;
  logic [3:0]        rx_count;
  sbpe_pkg::reply_t  reply_kind;
  logic [7:0]        rx_error;
  logic [7:0]        rx_param_low;
  logic [7:0]        rx_param_high;

  logic out_free, accept, run_step, emit, jump_take, rx_update, rx_report, rx_done;
  logic [8:0]  mag_ang;
  logic [33:0] prod2;
  logic signed [11:0] pos_s;
  logic [9:0]  pos;
  logic [10:0] spd_abs;
  logic [9:0]  vmag;
  logic [7:0]  tx_b;
  logic [3:0]  cnt_inc;
  logic [7:0]  err_n, lo_n, hi_n;
  logic        ok_n;
  logic [16:0] val_n;

  assign out_free = !m_tvalid || m_tready;
  assign uw       = sbpe_pkg::ucode(pc);
  assign accept   = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sbpe_pkg::ST_IDLE: begin
        if (accept) begin
          if (sbpe_pkg::op_t'(s_tuser) == sbpe_pkg::OP_RX) begin
            state_next = sbpe_pkg::ST_RX;
          end else if (sbpe_pkg::pkt_len(sbpe_pkg::op_t'(s_tuser)) <=
                       5'(sbpe_pkg::MAX_PACKET_BYTES)) begin
            state_next = sbpe_pkg::ST_RUN;
          end
        end
      end
      sbpe_pkg::ST_RUN: begin
        if (run_step && uw.done) state_next = sbpe_pkg::ST_IDLE;
      end
      sbpe_pkg::ST_RX: begin
        if (rx_done) state_next = sbpe_pkg::ST_IDLE;
      end
      default: state_next = sbpe_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == sbpe_pkg::ST_IDLE);
    run_step  = (state == sbpe_pkg::ST_RUN) &&
                (uw.act != sbpe_pkg::ACT_EMIT || out_free);
    emit      = run_step && uw.act == sbpe_pkg::ACT_EMIT;
    jump_take = uw.cnd == sbpe_pkg::CND_ALWAYS || op_q == sbpe_pkg::OP_JOINT_MODE;
    rx_update = 1'b0;
    rx_report = 1'b0;
    rx_done   = 1'b0;
    if (state == sbpe_pkg::ST_RX) begin
      if (rx_expected == 4'd0) begin
        rx_done = 1'b1;
      end else if (cnt_inc != rx_expected) begin
        rx_update = 1'b1;
        rx_done   = 1'b1;
      end else if (out_free) begin
        rx_update = 1'b1;
        rx_report = 1'b1;
        rx_done   = 1'b1;
      end
    end
  end

  // angle to position: |a|*341, /100 by reciprocal, sign, +665, clamp
  assign mag_ang = ang_q[8] ? (~ang_q + 9'd1) : ang_q;
  assign prod2   = {17'b0, prod1} * {17'b0, sbpe_pkg::RECIP_100};
  assign pos_s   = ang_q[8] ? $signed(sbpe_pkg::POS_CENTER) - $signed({2'b0, quo})
                            : $signed(sbpe_pkg::POS_CENTER) + $signed({2'b0, quo});
  assign pos     = pos_s[11] ? 10'd0 :
                   (pos_s > $signed({2'b0, sbpe_pkg::POS_MAX})) ? sbpe_pkg::POS_MAX :
                   pos_s[9:0];

  assign spd_abs = spd_q[10] ? (~spd_q + 11'd1) : spd_q;
  assign vmag    = spd_abs[10] ? sbpe_pkg::POS_MAX : spd_abs[9:0];

  always_comb begin
    case (uw.src)
      sbpe_pkg::SRC_HDR:  tx_b = sbpe_pkg::HDR_BYTE;
      sbpe_pkg::SRC_ID:   tx_b = id_q;
      sbpe_pkg::SRC_INS:  tx_b = dfr_q ? sbpe_pkg::INS_REG_WRITE : sbpe_pkg::INS_WRITE;
      sbpe_pkg::SRC_POSL: tx_b = pos[7:0];
      sbpe_pkg::SRC_POSH: tx_b = {6'b0, pos[9:8]};
      sbpe_pkg::SRC_SPDL: tx_b = spd_q[10] ? 8'h00 : spd_q[7:0];
      sbpe_pkg::SRC_SPDH: tx_b = spd_q[10] ? 8'h00 : {5'b0, spd_q[10:8]};
      sbpe_pkg::SRC_VELL: tx_b = vmag[7:0];
      sbpe_pkg::SRC_VELH: tx_b = (spd_q[10] ? 8'h00 : sbpe_pkg::WHEEL_FWD) |
                                 {6'b0, vmag[9:8]};
      sbpe_pkg::SRC_SUM:  tx_b = ~tx_sum;
      default:            tx_b = uw.imm;
    endcase
  end

  // reply capture and report
  assign cnt_inc = rx_count + 4'd1;
  assign err_n   = (rx_count == 4'd4) ? rxb_q : rx_error;
  assign lo_n    = (rx_count == 4'd5) ? rxb_q : rx_param_low;
  assign hi_n    = (rx_count == 4'd6) ? rxb_q : rx_param_high;
  assign ok_n    = (err_n == 8'h00);

  always_comb begin
    case (reply_kind)
      sbpe_pkg::RK_POS: val_n = ok_n ? {1'b0, hi_n, lo_n} : 17'h1FFFF;
      sbpe_pkg::RK_MOV: val_n = {16'b0, ok_n && lo_n != 8'h00};
      default:          val_n = 17'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sbpe_pkg::ST_IDLE;
      pc            <= '0;
      m_tvalid      <= 1'b0;
      rx_expected   <= '0;
      rx_count      <= '0;
      reply_kind    <= sbpe_pkg::RK_ACK;
      rx_error      <= '0;
      rx_param_low  <= '0;
      rx_param_high <= '0;
      tx_sum        <= '0;
    end else begin
      state <= state_next;
      if (emit || rx_report) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept) begin
        op_q  <= sbpe_pkg::op_t'(s_tuser);
        id_q  <= s_tdata[7:0];
        ang_q <= s_tdata[16:8];
        spd_q <= s_tdata[27:17];
        dfr_q <= s_tdata[28];
        rxb_q <= s_tdata[36:29];
        pc    <= sbpe_pkg::entry_pc(sbpe_pkg::op_t'(s_tuser));
        if (state_next == sbpe_pkg::ST_RUN) begin
          tx_sum      <= '0;
          rx_count    <= '0;
          rx_expected <= sbpe_pkg::reply_len(sbpe_pkg::op_t'(s_tuser));
          reply_kind  <= sbpe_pkg::reply_of(sbpe_pkg::op_t'(s_tuser));
        end
      end

      if (run_step) begin
        pc <= (uw.act == sbpe_pkg::ACT_JMP && jump_take) ? uw.target : pc + 6'd1;
        case (uw.act)
          sbpe_pkg::ACT_MUL1: prod1 <= {8'b0, mag_ang} * {8'b0, sbpe_pkg::ANGLE_SCALE};
          sbpe_pkg::ACT_MUL2: quo   <= prod2[sbpe_pkg::RECIP_SHIFT +: 10];
          default: ;
        endcase
      end

      if (emit) begin
        m_tdata  <= {6'b0, 17'd0, 1'b0, tx_b};
        m_tlast  <= uw.done;
        m_tuser  <= sbpe_pkg::KIND_TX;
        if (uw.src != sbpe_pkg::SRC_HDR && uw.src != sbpe_pkg::SRC_SUM) begin
          tx_sum <= tx_sum + tx_b;
        end
      end

      if (rx_update) begin
        rx_error      <= err_n;
        rx_param_low  <= lo_n;
        rx_param_high <= hi_n;
        rx_count      <= rx_report ? 4'd0 : cnt_inc;
      end
      if (rx_report) begin
        rx_expected <= '0;
        m_tdata     <= {6'b0, val_n, ok_n, 8'h00};
        m_tlast     <= 1'b0;
        m_tuser     <= sbpe_pkg::KIND_REPORT;
      end
    end
  end

endmodule
